FILE: rtl/atvc_pkg.sv
// ============================================================================
// atvc_pkg - shared types and constants for the vent controller
// Field widths, command and register codes, drive and mode codes, and the
// configuration and tick structs passed between the controller modules.
// ============================================================================
package atvc_pkg;

    localparam int CmdW  = 3;
    localparam int TimeW = 32;
    localparam int AltW  = 19;
    localparam int PosW  = 12;
    localparam int CntW  = 8;
    localparam int PerW  = 16;
    localparam int DrvW  = 2;
    localparam int ModeW = 2;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    localparam logic [CntW-1:0] CountMax = '1;

    // Ground command codes
    typedef enum logic [CmdW-1:0] {
        CMD_NONE       = 3'd0,
        CMD_ENABLE     = 3'd1,
        CMD_DATA_REQ   = 3'd2,
        CMD_ABORT      = 3'd3,
        CMD_VENT_NOW   = 3'd4,
        CMD_TEST_OPEN  = 3'd5,
        CMD_TEST_CLOSE = 3'd6,
        CMD_TEST_FAN   = 3'd7
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_MIN_ALT      = 3'd0,
        REG_MAX_ALT      = 3'd1,
        REG_OPEN_DUR     = 3'd2,
        REG_CHECKS       = 3'd3,
        REG_LOG_PERIOD   = 3'd4,
        REG_CMD_HOLDOFF  = 3'd5,
        REG_OPEN_END     = 3'd6,
        REG_CLOSED_END   = 3'd7
    } cfg_idx_t;

    // Actuator drive codes as seen at the output
    typedef enum logic [DrvW-1:0] {
        DRV_STOP  = 2'd0,
        DRV_OPEN  = 2'd1,
        DRV_CLOSE = 2'd2
    } drive_t;

    // Valve mode codes as seen at the output
    localparam logic [ModeW-1:0] ModeCodeArmed    = 2'd0;
    localparam logic [ModeW-1:0] ModeCodeOpen     = 2'd1;
    localparam logic [ModeW-1:0] ModeCodeDisarmed = 2'd2;

    // Valve state machine, one-hot
    typedef enum logic [2:0] {
        VS_ARMED    = 3'b001,
        VS_OPEN     = 3'b010,
        VS_DISARMED = 3'b100
    } valve_state_t;

    // Reset values of the configuration registers
    localparam logic signed [AltW-1:0] MinAltReset     = 19'sd18000;
    localparam logic signed [AltW-1:0] MaxAltReset     = 19'sd22000;
    localparam logic [TimeW-1:0]       OpenDurReset    = 32'd300000;
    localparam logic [CntW-1:0]        ChecksReset     = 8'd40;
    localparam logic [PerW-1:0]        LogPeriodReset  = 16'd500;
    localparam logic [PerW-1:0]        HoldoffReset    = 16'd1000;
    localparam logic [PosW-1:0]        OpenEndReset    = 12'd100;
    localparam logic [PosW-1:0]        ClosedEndReset  = 12'd3995;

    typedef struct packed {
        logic signed [AltW-1:0] min_altitude;
        logic signed [AltW-1:0] max_altitude;
        logic [TimeW-1:0]       open_duration_ms;
        logic [CntW-1:0]        checks_to_open;
        logic [PerW-1:0]        log_period_ms;
        logic [PerW-1:0]        command_holdoff_ms;
        logic [PosW-1:0]        open_end_position;
        logic [PosW-1:0]        closed_end_position;
    } cfg_t;

    typedef struct packed {
        logic [CmdW-1:0]        command;
        logic [TimeW-1:0]       now_ms;
        logic signed [AltW-1:0] altitude_m;
        logic [PosW-1:0]        actuator_position;
    } tick_in_t;

    typedef struct packed {
        logic [DrvW-1:0]  actuator_drive;
        logic             fan_on;
        logic [ModeW-1:0] valve_mode;
        logic             log_now;
        logic [CmdW-1:0]  reply;
    } tick_out_t;

    function automatic logic [ModeW-1:0] mode_code(valve_state_t vs);
        logic [ModeW-1:0] code;
        case (vs)
            VS_ARMED:    code = ModeCodeArmed;
            VS_OPEN:     code = ModeCodeOpen;
            VS_DISARMED: code = ModeCodeDisarmed;
            default:     code = ModeCodeArmed;
        endcase
        return code;
    endfunction

endpackage

FILE: rtl/atvc_cfg.sv
// ============================================================================
// atvc_cfg - configuration register file
// Holds the eight controller settings, written one at a time by index.
// ============================================================================
module atvc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [atvc_pkg::CfgIdxW-1:0]  wr_index,
    input  logic [atvc_pkg::CfgDataW-1:0] wr_data,
    output atvc_pkg::cfg_t                cfg
);
    import atvc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                REG_MIN_ALT:     cfg_next.min_altitude        = signed'(wr_data[AltW-1:0]);
                REG_MAX_ALT:     cfg_next.max_altitude        = signed'(wr_data[AltW-1:0]);
                REG_OPEN_DUR:    cfg_next.open_duration_ms    = wr_data[TimeW-1:0];
                REG_CHECKS:      cfg_next.checks_to_open      = wr_data[CntW-1:0];
                REG_LOG_PERIOD:  cfg_next.log_period_ms       = wr_data[PerW-1:0];
                REG_CMD_HOLDOFF: cfg_next.command_holdoff_ms  = wr_data[PerW-1:0];
                REG_OPEN_END:    cfg_next.open_end_position   = wr_data[PosW-1:0];
                REG_CLOSED_END:  cfg_next.closed_end_position = wr_data[PosW-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_altitude        <= MinAltReset;
            cfg_reg.max_altitude        <= MaxAltReset;
            cfg_reg.open_duration_ms    <= OpenDurReset;
            cfg_reg.checks_to_open      <= ChecksReset;
            cfg_reg.log_period_ms       <= LogPeriodReset;
            cfg_reg.command_holdoff_ms  <= HoldoffReset;
            cfg_reg.open_end_position   <= OpenEndReset;
            cfg_reg.closed_end_position <= ClosedEndReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/atvc_tick.sv
// ============================================================================
// atvc_tick - per-tick controller logic
// Holds the valve state, confirmation count and timestamps, and works out
// one tick's result from the registered input item in a single pass.
// ============================================================================
module atvc_tick (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  atvc_pkg::tick_in_t  item,
    input  atvc_pkg::cfg_t      cfg,
    output atvc_pkg::tick_out_t result
);
    import atvc_pkg::*;

    valve_state_t     state_reg, state_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic [TimeW-1:0] opened_at_reg, opened_at_next;
    logic [TimeW-1:0] last_log_reg, last_log_next;
    logic [TimeW-1:0] last_cmd_reg, last_cmd_next;
    logic             fan_reg, fan_next;

    logic [TimeW-1:0] cmd_elapsed;
    logic [TimeW-1:0] log_elapsed;
    logic             cmd_take;
    logic             strobe;
    logic             in_window;
    logic [DrvW-1:0]  drive;
    logic [TimeW-1:0] close_old;
    logic [TimeW-1:0] close_now;
    valve_state_t     st_cmd;
    logic [CntW-1:0]  cnt_cmd;
    logic [TimeW-1:0] open_cmd;
    logic             fan_cmd;
    logic             vent_taken;

    assign cmd_elapsed = item.now_ms - last_cmd_reg;
    assign log_elapsed = item.now_ms - last_log_reg;
    assign cmd_take    = (cmd_t'(item.command) != CMD_NONE) &&
                         (cmd_elapsed > TimeW'(cfg.command_holdoff_ms));
    assign strobe      = log_elapsed > TimeW'(cfg.log_period_ms);
    assign in_window   = (item.altitude_m > cfg.min_altitude) &&
                         (item.altitude_m < cfg.max_altitude);
    // closing deadline for either source of the open timestamp
    assign close_old   = opened_at_reg + cfg.open_duration_ms;
    assign close_now   = item.now_ms + cfg.open_duration_ms;

    always_comb
    begin
        // drive toward the endpoint of the current mode
        if (state_reg == VS_OPEN)
            drive = (item.actuator_position < cfg.open_end_position) ? DRV_STOP : DRV_OPEN;
        else
            drive = (item.actuator_position > cfg.closed_end_position) ? DRV_STOP : DRV_CLOSE;

        st_cmd     = state_reg;
        cnt_cmd    = count_reg;
        open_cmd   = opened_at_reg;
        fan_cmd    = fan_reg;
        vent_taken = 1'b0;
        last_cmd_next = last_cmd_reg;

        if (cmd_take)
        begin
            last_cmd_next = item.now_ms;
            case (cmd_t'(item.command))
                CMD_ENABLE:
                begin
                    st_cmd  = VS_ARMED;
                    cnt_cmd = '0;
                end
                CMD_ABORT:
                begin
                    st_cmd  = VS_DISARMED;
                    fan_cmd = 1'b0;
                    drive   = DRV_CLOSE;
                end
                CMD_VENT_NOW:
                begin
                    st_cmd     = VS_OPEN;
                    drive      = DRV_OPEN;
                    fan_cmd    = 1'b1;
                    open_cmd   = item.now_ms;
                    vent_taken = 1'b1;
                end
                CMD_TEST_OPEN:
                begin
                    st_cmd = VS_OPEN;
                    drive  = DRV_OPEN;
                end
                CMD_TEST_CLOSE: drive   = DRV_CLOSE;
                CMD_TEST_FAN:   fan_cmd = 1'b1;
                default:        ;
            endcase
        end

        last_log_next  = strobe ? item.now_ms : last_log_reg;
        state_next     = st_cmd;
        count_next     = cnt_cmd;
        opened_at_next = open_cmd;
        fan_next       = fan_cmd;

        if (st_cmd != VS_DISARMED)
        begin
            if (strobe && in_window && (cnt_cmd != CountMax))
                count_next = cnt_cmd + 1'b1;
            if ((count_next >= cfg.checks_to_open) && (st_cmd == VS_ARMED))
            begin
                state_next     = VS_OPEN;
                fan_next       = 1'b1;
                opened_at_next = item.now_ms;
            end
            else if ((st_cmd == VS_OPEN) &&
                     (item.now_ms > (vent_taken ? close_now : close_old)))
            begin
                state_next = VS_DISARMED;
                fan_next   = 1'b0;
            end
        end

        result.actuator_drive = drive;
        result.fan_on         = fan_next;
        result.valve_mode     = mode_code(state_next);
        result.log_now        = strobe;
        result.reply          = cmd_take ? item.command : CmdW'(CMD_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= VS_ARMED;
            count_reg     <= '0;
            opened_at_reg <= '0;
            last_log_reg  <= '0;
            last_cmd_reg  <= '0;
            fan_reg       <= 1'b0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            opened_at_reg <= opened_at_next;
            last_log_reg  <= last_log_next;
            last_cmd_reg  <= last_cmd_next;
            fan_reg       <= fan_next;
        end
    end

endmodule

FILE: rtl/altitude_triggered_vent_controller.sv
// ============================================================================
// altitude_triggered_vent_controller - vent valve and fan control per tick
// Takes one control tick per request (time, altitude, actuator position,
// ground command) and returns the actuator drive, fan, valve mode, log
// strobe and command reply for that tick.
// ============================================================================
//
//  Channel   Handshake               Payload
//  --------  ----------------------  -----------------------------------------
//  in        in_valid / in_stall     command, now_ms, altitude_m,
//                                    actuator_position
//  out       out_valid / out_stall   actuator_drive, fan_on, valve_mode,
//                                    log_now, reply
//  cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  One request per cycle sustained while the output does not stall. A request
//  is held in the input register and its result is loaded into the output
//  register. The controller state updates in the same edge that loads the
//  result register. Reset clears all state and loads the default settings.
//  A stall on the output holds the result register and the input register;
//  the input side stalls only while both are full.
//
module altitude_triggered_vent_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    // tick requests
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [atvc_pkg::CmdW-1:0]     command,
    input  logic [atvc_pkg::TimeW-1:0]    now_ms,
    input  logic signed [atvc_pkg::AltW-1:0] altitude_m,
    input  logic [atvc_pkg::PosW-1:0]     actuator_position,
    // tick results
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [atvc_pkg::DrvW-1:0]     actuator_drive,
    output logic                          fan_on,
    output logic [atvc_pkg::ModeW-1:0]    valve_mode,
    output logic                          log_now,
    output logic [atvc_pkg::CmdW-1:0]     reply,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [atvc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [atvc_pkg::CfgDataW-1:0] cfg_data
);
    import atvc_pkg::*;

    cfg_t      cfg;
    tick_in_t  item_reg;
    logic      item_valid_reg;
    tick_out_t result;
    tick_out_t result_reg;
    logic      result_valid_reg;
    logic      advance;
    logic      item_load;

    // Settings are always writable; writes should land only while idle, which the user must ensure: the block does not.
    assign cfg_ready = 1'b1;

    atvc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Move the held request into the result register when there is room.
    assign advance   = item_valid_reg && (!result_valid_reg || !out_stall);
    // Refill the input register when it is empty or draining this cycle.
    assign item_load = !item_valid_reg || advance;
    assign in_stall  = !item_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_load)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load && in_valid)
        begin
            item_reg.command           <= command;
            item_reg.now_ms            <= now_ms;
            item_reg.altitude_m        <= altitude_m;
            item_reg.actuator_position <= actuator_position;
        end
    end

    atvc_tick u_tick (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Hold the result while the consumer stalls; drop valid once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = result_valid_reg;
    assign actuator_drive = result_reg.actuator_drive;
    assign fan_on         = result_reg.fan_on;
    assign valve_mode     = result_reg.valve_mode;
    assign log_now        = result_reg.log_now;
    assign reply          = result_reg.reply;

endmodule

FILE: dv/tb_altitude_triggered_vent_controller.sv
// ============================================================================
// tb_altitude_triggered_vent_controller - self-checking bench for the vent
// controller
// Drives control ticks through the request channel while the result channel
// stalls at random. A behavioral model of the valve, fan, log strobe and
// command logic predicts every result, and each result is compared field by
// field. Directed ticks cover the corner cases, then random flights run under
// changing register settings.
// ============================================================================
module tb_altitude_triggered_vent_controller;

    import atvc_pkg::*;

    localparam int ClkPeriod     = 8;
    localparam int ResetCycles   = 7;
    // Result passes through the input and result registers; leave margin.
    localparam int SettleCycles  = 4;
    // Cycles without any handshake before the run is declared hung.
    localparam int WatchdogLimit = 1000;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    logic                   in_valid;
    logic                   in_stall;
    logic [CmdW-1:0]        command;
    logic [TimeW-1:0]       now_ms;
    logic signed [AltW-1:0] altitude_m;
    logic [PosW-1:0]        actuator_position;

    logic                   out_valid;
    logic                   out_stall;
    logic [DrvW-1:0]        actuator_drive;
    logic                   fan_on;
    logic [ModeW-1:0]       valve_mode;
    logic                   log_now;
    logic [CmdW-1:0]        reply;

    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CfgIdxW-1:0]     cfg_index;
    logic [CfgDataW-1:0]    cfg_data;

    always #(ClkPeriod / 2) clk = ~clk;

    altitude_triggered_vent_controller DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .command           (command),
        .now_ms            (now_ms),
        .altitude_m        (altitude_m),
        .actuator_position (actuator_position),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .actuator_drive    (actuator_drive),
        .fan_on            (fan_on),
        .valve_mode        (valve_mode),
        .log_now           (log_now),
        .reply             (reply),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    int send_idle_pct  = 0;     // chance in percent that the sender skips a cycle
    int recv_stall_pct = 0;     // chance in percent that the receiver stalls a cycle

    tick_out_t expected_vent_outputs[$];
    int        mismatches     = 0;
    int        ticks_sent     = 0;
    int        results_seen   = 0;
    int        reg_writes     = 0;
    int        stuck_cycles   = 0;
    logic [TimeW-1:0] flight_clock_ms = '0;

    // Shadow copy of the controller: settings plus valve state.
    cfg_t             cfg_shadow;
    logic [ModeW-1:0] vent_mode;
    logic [CntW-1:0]  confirm_cnt;
    logic [TimeW-1:0] opened_at;
    logic [TimeW-1:0] last_log_at;
    logic [TimeW-1:0] last_cmd_at;
    logic             fan_state;

    // Coverage tallies for the closing summary.
    int cmds_accepted  = 0;
    int auto_openings  = 0;
    int timed_disarms  = 0;
    int strobes_seen   = 0;
    int peak_count     = 0;

    // ------------------------------------------------------------------------
    // Vent model
    // ------------------------------------------------------------------------
    function automatic void reset_vent_model();
        cfg_shadow = '{min_altitude:        MinAltReset,
                       max_altitude:        MaxAltReset,
                       open_duration_ms:    OpenDurReset,
                       checks_to_open:      ChecksReset,
                       log_period_ms:       LogPeriodReset,
                       command_holdoff_ms:  HoldoffReset,
                       open_end_position:   OpenEndReset,
                       closed_end_position: ClosedEndReset};
        vent_mode   = ModeCodeArmed;
        confirm_cnt = '0;
        opened_at   = '0;
        last_log_at = '0;
        last_cmd_at = '0;
        fan_state   = 1'b0;
    endfunction

    function automatic void shadow_reg_write(cfg_idx_t idx, logic [CfgDataW-1:0] data);
        case (idx)
            REG_MIN_ALT:     cfg_shadow.min_altitude        = data[AltW-1:0];
            REG_MAX_ALT:     cfg_shadow.max_altitude        = data[AltW-1:0];
            REG_OPEN_DUR:    cfg_shadow.open_duration_ms    = data[TimeW-1:0];
            REG_CHECKS:      cfg_shadow.checks_to_open      = data[CntW-1:0];
            REG_LOG_PERIOD:  cfg_shadow.log_period_ms       = data[PerW-1:0];
            REG_CMD_HOLDOFF: cfg_shadow.command_holdoff_ms  = data[PerW-1:0];
            REG_OPEN_END:    cfg_shadow.open_end_position   = data[PosW-1:0];
            REG_CLOSED_END:  cfg_shadow.closed_end_position = data[PosW-1:0];
            default: ;
        endcase
    endfunction

    // Advance the shadow valve by one tick and return what the block must show.
    function automatic tick_out_t predict_vent_tick(tick_in_t t);
        tick_out_t              res;
        logic                   strobe;
        logic signed [AltW-1:0] alt;
        logic signed [AltW-1:0] alt_lo;
        logic signed [AltW-1:0] alt_hi;
        logic [TimeW-1:0]       close_at;

        res    = '0;
        alt    = t.altitude_m;
        alt_lo = cfg_shadow.min_altitude;
        alt_hi = cfg_shadow.max_altitude;

        // Drive toward the endpoint of the mode held at the start of the tick.
        if (vent_mode == ModeCodeOpen)
            res.actuator_drive = (t.actuator_position < cfg_shadow.open_end_position)
                                 ? DRV_STOP : DRV_OPEN;
        else
            res.actuator_drive = (t.actuator_position > cfg_shadow.closed_end_position)
                                 ? DRV_STOP : DRV_CLOSE;

        // Take the command only once the holdoff since the last one has passed.
        if (t.command != CMD_NONE &&
            (t.now_ms - last_cmd_at) > TimeW'(cfg_shadow.command_holdoff_ms))
        begin
            case (cmd_t'(t.command))
                CMD_ENABLE:
                begin
                    vent_mode   = ModeCodeArmed;
                    confirm_cnt = '0;
                end
                CMD_ABORT:
                begin
                    vent_mode          = ModeCodeDisarmed;
                    fan_state          = 1'b0;
                    res.actuator_drive = DRV_CLOSE;
                end
                CMD_VENT_NOW:
                begin
                    vent_mode          = ModeCodeOpen;
                    res.actuator_drive = DRV_OPEN;
                    fan_state          = 1'b1;
                    opened_at          = t.now_ms;
                end
                CMD_TEST_OPEN:
                begin
                    // keep the old open timestamp
                    vent_mode          = ModeCodeOpen;
                    res.actuator_drive = DRV_OPEN;
                end
                CMD_TEST_CLOSE: res.actuator_drive = DRV_CLOSE;
                CMD_TEST_FAN:   fan_state = 1'b1;
                default: ;
            endcase
            last_cmd_at = t.now_ms;
            res.reply   = t.command;
            cmds_accepted++;
        end

        strobe = (t.now_ms - last_log_at) > TimeW'(cfg_shadow.log_period_ms);
        if (strobe)
        begin
            last_log_at = t.now_ms;
            strobes_seen++;
        end

        if (vent_mode != ModeCodeDisarmed)
        begin
            if (strobe && alt > alt_lo && alt < alt_hi && confirm_cnt != CountMax)
                confirm_cnt++;
            if (int'(confirm_cnt) > peak_count)
                peak_count = confirm_cnt;
            close_at = opened_at + cfg_shadow.open_duration_ms;
            if (confirm_cnt >= cfg_shadow.checks_to_open && vent_mode == ModeCodeArmed)
            begin
                vent_mode = ModeCodeOpen;
                fan_state = 1'b1;
                opened_at = t.now_ms;
                auto_openings++;
            end
            else if (vent_mode == ModeCodeOpen && t.now_ms > close_at)
            begin
                // plain compare against the wrapped sum
                vent_mode = ModeCodeDisarmed;
                fan_state = 1'b0;
                timed_disarms++;
            end
        end

        res.fan_on     = fan_state;
        res.valve_mode = vent_mode;
        res.log_now    = strobe;
        return res;
    endfunction

    function automatic tick_in_t make_tick(cmd_t c, logic [TimeW-1:0] stamp, int alt, int pos);
        tick_in_t r;
        r.command           = c;
        r.now_ms            = stamp;
        r.altitude_m        = alt[AltW-1:0];
        r.actuator_position = pos[PosW-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side. Every task starts and ends at a falling edge; in_valid is
    // left high on return so that back-to-back requests need no second
    // assignment in the same step. Drop it with wait_idle before any pause.
    // ------------------------------------------------------------------------
    task automatic send_tick(tick_in_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid          <= 1'b1;
        command           <= t.command;
        now_ms            <= t.now_ms;
        altitude_m        <= t.altitude_m;
        actuator_position <= t.actuator_position;
        // Hold the request until an edge sees it unstalled.
        do @(posedge clk); while (in_stall);
        expected_vent_outputs.push_back(predict_vent_tick(t));
        ticks_sent++;
        @(negedge clk);
    endtask

    // Drop the request line, drain every pending result, then let the
    // pipeline settle so that register writes land on an idle block.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_vent_outputs.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        shadow_reg_write(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall, checking and the watchdog
    // ------------------------------------------------------------------------
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        tick_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_vent_outputs.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no request pending: expected none, actual %0d %0d %0d %0d %0d",
                         $time, actuator_drive, fan_on, valve_mode, log_now, reply);
            end
            else
            begin
                want = expected_vent_outputs.pop_front();
                check_field("actuator_drive", want.actuator_drive, actuator_drive);
                check_field("fan_on",         want.fan_on,         fan_on);
                check_field("valve_mode",     want.valve_mode,     valve_mode);
                check_field("log_now",        want.log_now,        log_now);
                check_field("reply",          want.reply,          reply);
            end
        end
    end

    // Count cycles in which no channel moves anything; a hung block ends here.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WatchdogLimit)
        begin
            $display("%0t: watchdog: no handshake for %0d cycles, %0d results pending",
                     $time, stuck_cycles, expected_vent_outputs.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Default settings: holdoff edge, every command, drive endpoints, the
    // test-open timestamp quirk and a disarm through a wrapped close time.
    task automatic test_commands_and_holdoff();
        send_tick(make_tick(CMD_ENABLE,     32'd0,        20000,   0));    // inside holdoff
        send_tick(make_tick(CMD_DATA_REQ,   32'd1001,    -100000,  4095));
        send_tick(make_tick(CMD_ABORT,      32'd2001,     200000,  3995)); // exactly at holdoff
        send_tick(make_tick(CMD_ABORT,      32'd2002,     18000,   3996));
        send_tick(make_tick(CMD_TEST_FAN,   32'd3003,     22000,   3995));
        send_tick(make_tick(CMD_ENABLE,     32'd4004,     21999,   2048));
        send_tick(make_tick(CMD_TEST_OPEN,  32'd5005,     18001,   99));
        send_tick(make_tick(CMD_TEST_CLOSE, 32'd6006,     20000,   99));
        send_tick(make_tick(CMD_NONE,       32'd6007,     20000,   100));
        // test open kept a zero timestamp, so the close time has passed
        send_tick(make_tick(CMD_NONE,       32'd300001,   20000,   1000));
        // open time plus duration wraps past zero: disarm on the same tick
        send_tick(make_tick(CMD_VENT_NOW,   32'hFFFF_F000, 20000,  4000));
        send_tick(make_tick(CMD_ENABLE,     32'hFFFF_FFFF, 20000,  0));
    endtask

    // A zero threshold opens on the first armed tick, strobe or not.
    task automatic test_zero_threshold();
        wait_idle();
        write_reg(REG_CHECKS, 32'd0);
        send_tick(make_tick(CMD_NONE, 32'h0000_0010, -1, 4095));
    endtask

    // Inverted and empty windows never count; a one-meter window does.
    task automatic test_altitude_window();
        wait_idle();
        write_reg(REG_MIN_ALT, 32'd22000);
        write_reg(REG_MAX_ALT, 32'd18000);
        write_reg(REG_CHECKS,  32'd1);
        send_tick(make_tick(CMD_ENABLE, 32'h0000_2000, 20000, 500));
        send_tick(make_tick(CMD_NONE,   32'h0000_3000, 20000, 500));
        wait_idle();
        write_reg(REG_MIN_ALT, 32'd20000);
        write_reg(REG_MAX_ALT, 32'd20000);
        send_tick(make_tick(CMD_NONE,   32'h0000_4000, 20000, 500));
        wait_idle();
        write_reg(REG_MIN_ALT, 32'd19999);
        write_reg(REG_MAX_ALT, 32'd20001);
        send_tick(make_tick(CMD_NONE,   32'h0000_5000, 20000, 500));
    endtask

    // Every register at one extreme, then at the other.
    task automatic test_register_extremes();
        wait_idle();
        write_reg(REG_MIN_ALT,     -100000);
        write_reg(REG_MAX_ALT,     200000);
        write_reg(REG_OPEN_DUR,    32'd0);
        write_reg(REG_CHECKS,      32'd255);
        write_reg(REG_LOG_PERIOD,  32'd0);
        write_reg(REG_CMD_HOLDOFF, 32'd0);
        write_reg(REG_OPEN_END,    32'd0);
        write_reg(REG_CLOSED_END,  32'd4095);
        send_tick(make_tick(CMD_ABORT,  32'h0000_6000, 0, 0));
        send_tick(make_tick(CMD_ENABLE, 32'h0000_6001, 0, 4095));
        send_tick(make_tick(CMD_ENABLE, 32'h0000_6001, 0, 4095));  // same ms: no holdoff pass
        wait_idle();
        write_reg(REG_MIN_ALT,     200000);
        write_reg(REG_MAX_ALT,     -100000);
        write_reg(REG_OPEN_DUR,    32'hFFFF_FFFF);
        write_reg(REG_CHECKS,      32'd0);
        write_reg(REG_LOG_PERIOD,  32'd65535);
        write_reg(REG_CMD_HOLDOFF, 32'd65535);
        write_reg(REG_OPEN_END,    32'd4095);
        write_reg(REG_CLOSED_END,  32'd0);
        send_tick(make_tick(CMD_NONE,       32'h0000_7000, 150000, 4094));
        send_tick(make_tick(CMD_TEST_CLOSE, 32'h0000_7000, 150000, 4095));
        send_tick(make_tick(CMD_VENT_NOW,   32'h0001_7000, -50000, 0));
    endtask

    // Pick a fresh set of settings, mostly ones that let a flight cycle
    // through arm, count, open and disarm within a few hundred ticks.
    task automatic apply_random_settings();
        int lo;
        int hi;
        int roll;

        roll = $urandom_range(99);
        if (roll < 10)
        begin
            lo = -100000;
            hi = 200000;
        end
        else
        begin
            lo = $urandom_range(0, 300000) - 100000;
            if (roll < 20)
                hi = lo - int'($urandom_range(0, 5000));
            else
                hi = lo + int'($urandom_range(1, 20000));
            if (hi > 200000)
                hi = 200000;
            if (hi < -100000)
                hi = -100000;
        end
        write_reg(REG_MIN_ALT, lo);
        write_reg(REG_MAX_ALT, hi);
        roll = $urandom_range(99);
        write_reg(REG_OPEN_DUR, roll < 60 ? $urandom_range(0, 5000) :
                                roll < 90 ? $urandom_range(0, 200000) : $urandom);
        roll = $urandom_range(99);
        write_reg(REG_CHECKS, roll < 70 ? $urandom_range(0, 6) :
                              roll < 90 ? $urandom_range(7, 40) : $urandom_range(41, 255));
        roll = $urandom_range(99);
        write_reg(REG_LOG_PERIOD, roll < 60 ? $urandom_range(0, 300) :
                                  roll < 90 ? $urandom_range(0, 3000) : $urandom_range(0, 65535));
        roll = $urandom_range(99);
        write_reg(REG_CMD_HOLDOFF, roll < 60 ? $urandom_range(0, 300) :
                                   roll < 90 ? $urandom_range(0, 3000) : $urandom_range(0, 65535));
        write_reg(REG_OPEN_END,   $urandom_range(0, 4095));
        write_reg(REG_CLOSED_END, $urandom_range(0, 4095));
    endtask

    // Random flights: time mostly moves forward in steps scaled to the log
    // period and holdoff, altitude mostly sits in the window, commands are
    // sparse and a disarmed valve tends to get re-enabled. A few far jumps
    // wrap the clock.
    task automatic test_random_flights(int n_ticks);
        int               sent;
        int               flight_len;
        int               roll;
        int               alt;
        int               pos;
        int               lo_alt;
        int               hi_alt;
        logic [TimeW-1:0] advance_ms;
        tick_in_t         t;

        sent = 0;
        while (sent < n_ticks)
        begin
            wait_idle();
            apply_random_settings();
            flight_len = $urandom_range(30, 150);
            if ($urandom_range(9) == 0)
            begin
                // long haul: drive the confirmation count to saturation
                write_reg(REG_CHECKS,     32'd255);
                write_reg(REG_LOG_PERIOD, 32'd0);
                flight_len = 300;
            end
            // trim the last flight so the tick budget is not overshot
            if (flight_len > n_ticks - sent)
                flight_len = n_ticks - sent;
            if ($urandom_range(2) == 0)
                flight_clock_ms = $urandom;
            lo_alt = $signed(cfg_shadow.min_altitude);
            hi_alt = $signed(cfg_shadow.max_altitude);

            repeat (flight_len)
            begin
                roll = $urandom_range(99);
                if (roll < 10)
                    advance_ms = '0;
                else if (roll < 60)
                    advance_ms = $urandom_range(0, 2 * cfg_shadow.log_period_ms + 1);
                else if (roll < 90)
                    advance_ms = $urandom_range(0, 2 * cfg_shadow.command_holdoff_ms + 1);
                else if (roll < 97)
                    advance_ms = $urandom_range(0, cfg_shadow.open_duration_ms / 2 + 1);
                else
                    advance_ms = $urandom;
                flight_clock_ms += advance_ms;
                t.now_ms = flight_clock_ms;

                roll = $urandom_range(99);
                if (vent_mode == ModeCodeDisarmed && roll < 15)
                    t.command = CMD_ENABLE;
                else if (roll < 85)
                    t.command = CMD_NONE;
                else
                    t.command = $urandom_range(CMD_ENABLE, CMD_TEST_FAN);

                roll = $urandom_range(99);
                if (roll < 70 && hi_alt - lo_alt >= 2)
                    alt = lo_alt + 1 + int'($urandom_range(0, hi_alt - lo_alt - 2));
                else if (roll < 80)
                    alt = roll[0] ? lo_alt : hi_alt;
                else
                    alt = $urandom_range(0, 300000) - 100000;
                t.altitude_m = alt[AltW-1:0];

                // Hug the endpoints now and then so both sides of each compare show up.
                roll = $urandom_range(99);
                if (roll < 15)
                    pos = cfg_shadow.open_end_position + $urandom_range(0, 2) - 1;
                else if (roll < 30)
                    pos = cfg_shadow.closed_end_position + $urandom_range(0, 2) - 1;
                else
                    pos = $urandom_range(0, 4095);
                if (pos < 0)
                    pos = 0;
                if (pos > 4095)
                    pos = 4095;
                t.actuator_position = pos[PosW-1:0];

                send_tick(t);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // Hold every input at a known value through reset.
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        command           = CMD_NONE;
        now_ms            = '0;
        altitude_m        = '0;
        actuator_position = '0;
        out_stall         = 1'b0;
        cfg_valid         = 1'b0;
        cfg_index         = REG_MIN_ALT;
        cfg_data          = '0;
        reset_vent_model();
        repeat (ResetCycles) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Sender idles lightly, receiver stalls heavily.
        send_idle_pct  = 25;
        recv_stall_pct = 47;
        test_commands_and_holdoff();
        test_zero_threshold();
        test_altitude_window();
        test_register_extremes();
        test_random_flights(700);

        // Swap the pressure: sender starves, receiver mostly drains.
        send_idle_pct  = 47;
        recv_stall_pct = 25;
        test_random_flights(700);

        // Full rate on both sides.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_flights(600);

        wait_idle();
        $display("summary: %0d ticks and %0d results over %0d register writes; %0d commands taken",
                 ticks_sent, results_seen, reg_writes, cmds_accepted);
        $display("summary: %0d log strobes, %0d automatic openings, %0d timed disarms, count peak %0d",
                 strobes_seen, auto_openings, timed_disarms, peak_count);
        if (mismatches == 0 && expected_vent_outputs.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
rtl/atvc_pkg.sv
rtl/atvc_cfg.sv
rtl/atvc_tick.sv
rtl/altitude_triggered_vent_controller.sv
dv/tb_altitude_triggered_vent_controller.sv
